// ===== design/stp_bpdu_pkg.sv =====
// Package for the spanning-tree port role update unit.
// Types, port-role codes and sizing constants shared by all design files.
// No dependencies.
`timescale 1ns / 1ps

package stp_bpdu_pkg;

  localparam int NUM_PORTS = 32;
  localparam int PORT_W    = 5;
  localparam int ID_W      = 16;
  localparam int DIST_W    = 8;
  localparam int MASK_W    = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [1:0] ROLE_DESIG = 2'd0;
  localparam logic [1:0] ROLE_ROOT  = 2'd1;
  localparam logic [1:0] ROLE_BLOCK = 2'd2;

  localparam logic REG_OWN_ID = 1'b0;
  localparam logic REG_MASK   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   msg_root_id;
    logic [DIST_W-1:0] msg_distance;
    logic [ID_W-1:0]   msg_sender_id;
    logic [PORT_W-1:0] msg_port;
  } in_item_t;

  typedef struct packed {
    logic              changed;
    logic [ID_W-1:0]   best_root_id;
    logic [DIST_W-1:0] root_distance;
    logic [PORT_W-1:0] root_port;
  } out_item_t;

  typedef struct packed {
    in_item_t          msg;
    logic [DIST_W-1:0] next_dist;
    logic              port_ok;
  } cls_item_t;

  typedef struct packed {
    logic              own_we;
    logic              mask_we;
    logic [DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== design/stp_bpdu_port_role_update_unit.sv =====
// Top level of the spanning-tree port role update unit.
// Instantiates stp_bpdu_front and stp_bpdu_back; uses stp_bpdu_pkg.
//
// Usage:
//   Input queue port: push/full with in_item (root id, distance, sender id,
//   arrival port). A transfer happens at an edge with push high, full low.
//   Result queue port: empty/pop with out_item (changed flag, root id,
//   distance, root port). The oldest result shows while empty is low and
//   is transferred at an edge with pop high.
//   APB register port: own_bridge_id at 0x0, connected_port_mask at 0x4;
//   writes complete in the access phase, pready is tied high.
// Path: a message waits in the front-end queue, then the back end applies
//   it and writes its result into the result queue, where it can be popped.
// Throughput: one message per cycle while the result queue has room or is
//   popped; the back end updates its state combinationally per message.
// Reset (rst_n low, synchronous) empties both queues, clears registers and
//   sets every port designated. When the result side stalls, the two-entry
//   result queue and then the two-entry message queue fill, and full rises.
`timescale 1ns / 1ps

module stp_bpdu_port_role_update_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  stp_bpdu_pkg::in_item_t                in_item,
  output logic                                  full,
  output logic                                  empty,
  input  logic                                  pop,
  output stp_bpdu_pkg::out_item_t               out_item,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [stp_bpdu_pkg::ADDR_W-1:0]       paddr,
  input  logic [stp_bpdu_pkg::DATA_W-1:0]       pwdata,
  output logic [stp_bpdu_pkg::DATA_W-1:0]       prdata,
  output logic                                  pready
);

  logic                            q_valid, q_pop, wr_stb;
  stp_bpdu_pkg::cls_item_t         q_item;
  stp_bpdu_pkg::cfg_wr_t           cfg_wr;
  logic [stp_bpdu_pkg::ID_W-1:0]   own_id;
  logic [stp_bpdu_pkg::MASK_W-1:0] port_mask;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite && pready;

  always_comb begin
    cfg_wr.own_we  = wr_stb && (paddr[2] == stp_bpdu_pkg::REG_OWN_ID);
    cfg_wr.mask_we = wr_stb && (paddr[2] == stp_bpdu_pkg::REG_MASK);
    cfg_wr.wdata   = pwdata;
    if (paddr[2] == stp_bpdu_pkg::REG_OWN_ID) begin
      prdata = {{(stp_bpdu_pkg::DATA_W - stp_bpdu_pkg::ID_W){1'b0}}, own_id};
    end else begin
      prdata = port_mask;
    end
  end

  stp_bpdu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  stp_bpdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_wr    (cfg_wr),
    .own_id    (own_id),
    .port_mask (port_mask),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ===== design/stp_bpdu_front.sv =====
// Front end: accepts messages, precomputes the saturated candidate distance
// and the port range check, and holds them in a two-entry queue.
// Depends on stp_bpdu_pkg.
`timescale 1ns / 1ps

module stp_bpdu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  stp_bpdu_pkg::in_item_t in_item,
  output logic                   full,
  output logic                   q_valid,
  output stp_bpdu_pkg::cls_item_t q_item,
  input  logic                   q_pop
);

  stp_bpdu_pkg::cls_item_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;
  stp_bpdu_pkg::cls_item_t cls;

  always_comb begin
    cls.msg     = in_item;
    cls.port_ok = ({1'b0, in_item.msg_port} < (stp_bpdu_pkg::PORT_W + 1)'(stp_bpdu_pkg::NUM_PORTS));
    if (in_item.msg_distance == {stp_bpdu_pkg::DIST_W{1'b1}}) begin
      cls.next_dist = {stp_bpdu_pkg::DIST_W{1'b1}};
    end else begin
      cls.next_dist = in_item.msg_distance + 1'b1;
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wr_en ? !wp_r : wp_r;
    rp_nxt  = rd_en ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

// ===== design/stp_bpdu_back.sv =====
// Back end: bridge state, configuration registers and per-port roles.
// Applies one queued message per cycle and queues the result (two entries),
// unless that queue is full and not popped. Depends on stp_bpdu_pkg.
`timescale 1ns / 1ps

module stp_bpdu_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  stp_bpdu_pkg::cls_item_t   q_item,
  output logic                      q_pop,
  input  stp_bpdu_pkg::cfg_wr_t     cfg_wr,
  output logic [stp_bpdu_pkg::ID_W-1:0]   own_id,
  output logic [stp_bpdu_pkg::MASK_W-1:0] port_mask,
  output logic                      empty,
  input  logic                      pop,
  output stp_bpdu_pkg::out_item_t   out_item
);

  localparam int NP = stp_bpdu_pkg::NUM_PORTS;

  logic [stp_bpdu_pkg::ID_W-1:0]   own_r, own_nxt;
  logic [stp_bpdu_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic [stp_bpdu_pkg::ID_W-1:0]   root_r, root_nxt;
  logic [stp_bpdu_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [stp_bpdu_pkg::ID_W-1:0]   pid_r, pid_nxt;
  logic [stp_bpdu_pkg::PORT_W-1:0] pp_r, pp_nxt;
  logic                            has_r, has_nxt;
  logic [NP-1:0][1:0]              roles_r, roles_nxt;

  stp_bpdu_pkg::out_item_t omem_r [2];
  logic       owp_r, owp_nxt;
  logic       orp_r, orp_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       rd_en;

  stp_bpdu_pkg::in_item_t  m;
  stp_bpdu_pkg::out_item_t res;
  logic [1:0] role_p;
  logic lt_root, eq_root, nd_lt, nd_eq, nd_gt;
  logic do_adopt, do_move, do_block, take;

  assign own_id    = own_r;
  assign port_mask = mask_r;
  assign empty     = (ocnt_r == 2'd0);
  assign out_item  = omem_r[orp_r];
  assign rd_en     = pop && !empty;
  assign take      = q_valid && ((ocnt_r != 2'd2) || pop);
  assign q_pop     = take;
  assign m         = q_item.msg;

  always_comb begin
    role_p = stp_bpdu_pkg::ROLE_DESIG;
    for (int p = 0; p < NP; p++) begin
      if (stp_bpdu_pkg::PORT_W'(p) == m.msg_port) begin
        role_p = roles_r[p];
      end
    end
    lt_root = m.msg_root_id < root_r;
    eq_root = m.msg_root_id == root_r;
    nd_lt   = q_item.next_dist < dist_r;
    nd_eq   = q_item.next_dist == dist_r;
    nd_gt   = q_item.next_dist > dist_r;

    do_adopt = q_item.port_ok && (lt_root || (eq_root && nd_lt));
    do_move  = q_item.port_ok && eq_root && nd_eq && (m.msg_sender_id <= pid_r) &&
               ((m.msg_sender_id < pid_r) || !has_r || (m.msg_port < pp_r));
    do_block = q_item.port_ok && eq_root && (
                 (nd_eq && (m.msg_sender_id > pid_r) &&
                  (role_p == stp_bpdu_pkg::ROLE_DESIG)) ||
                 (nd_eq && (m.msg_sender_id == pid_r) && has_r && (m.msg_port > pp_r) &&
                  (role_p != stp_bpdu_pkg::ROLE_BLOCK)) ||
                 (nd_gt && (m.msg_distance == dist_r) && (m.msg_sender_id < own_r) &&
                  (role_p == stp_bpdu_pkg::ROLE_DESIG)));

    own_nxt   = own_r;
    mask_nxt  = mask_r;
    root_nxt  = root_r;
    dist_nxt  = dist_r;
    pid_nxt   = pid_r;
    pp_nxt    = pp_r;
    has_nxt   = has_r;
    roles_nxt = roles_r;

    if (take) begin
      if (do_adopt) begin
        if (lt_root) begin
          root_nxt = m.msg_root_id;
        end
        dist_nxt = q_item.next_dist;
        pid_nxt  = m.msg_sender_id;
        pp_nxt   = m.msg_port;
        has_nxt  = 1'b1;
        for (int p = 0; p < NP; p++) begin
          if (p < stp_bpdu_pkg::MASK_W) begin
            if (mask_r[p]) begin
              roles_nxt[p] = stp_bpdu_pkg::ROLE_DESIG;
            end
          end
          if (stp_bpdu_pkg::PORT_W'(p) == m.msg_port) begin
            roles_nxt[p] = stp_bpdu_pkg::ROLE_ROOT;
          end
        end
      end else if (do_move) begin
        pid_nxt = m.msg_sender_id;
        pp_nxt  = m.msg_port;
        has_nxt = 1'b1;
        for (int p = 0; p < NP; p++) begin
          if (has_r && (stp_bpdu_pkg::PORT_W'(p) == pp_r)) begin
            roles_nxt[p] = stp_bpdu_pkg::ROLE_BLOCK;
          end
          if (stp_bpdu_pkg::PORT_W'(p) == m.msg_port) begin
            roles_nxt[p] = stp_bpdu_pkg::ROLE_ROOT;
          end
        end
      end else if (do_block) begin
        for (int p = 0; p < NP; p++) begin
          if (stp_bpdu_pkg::PORT_W'(p) == m.msg_port) begin
            roles_nxt[p] = stp_bpdu_pkg::ROLE_BLOCK;
          end
        end
      end
    end

    if (cfg_wr.own_we) begin
      own_nxt = cfg_wr.wdata[stp_bpdu_pkg::ID_W-1:0];
      if (!has_r) begin
        root_nxt = cfg_wr.wdata[stp_bpdu_pkg::ID_W-1:0];
        pid_nxt  = cfg_wr.wdata[stp_bpdu_pkg::ID_W-1:0];
      end
    end
    if (cfg_wr.mask_we) begin
      mask_nxt = cfg_wr.wdata[stp_bpdu_pkg::MASK_W-1:0];
    end

    res.changed       = do_adopt || do_move || do_block;
    res.best_root_id  = root_nxt;
    res.root_distance = dist_nxt;
    res.root_port     = has_nxt ? pp_nxt : '0;

    owp_nxt  = take ? !owp_r : owp_r;
    orp_nxt  = rd_en ? !orp_r : orp_r;
    ocnt_nxt = ocnt_r + {1'b0, take} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= '0;
      mask_r  <= '0;
      root_r  <= '0;
      dist_r  <= '0;
      pid_r   <= '0;
      pp_r    <= '0;
      has_r   <= 1'b0;
      roles_r <= '0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      own_r   <= own_nxt;
      mask_r  <= mask_nxt;
      root_r  <= root_nxt;
      dist_r  <= dist_nxt;
      pid_r   <= pid_nxt;
      pp_r    <= pp_nxt;
      has_r   <= has_nxt;
      roles_r <= roles_nxt;
      owp_r   <= owp_nxt;
      orp_r   <= orp_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      omem_r[owp_r] <= res;
    end
  end

endmodule

// ===== design/stp_bpdu_chk.sv =====
// Port-level checker for the spanning-tree port role update unit.
// Bound to stp_bpdu_port_role_update_unit; uses stp_bpdu_pkg.
`timescale 1ns / 1ps

module stp_bpdu_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input stp_bpdu_pkg::out_item_t         out_item
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input queue full after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("pending result changed before transfer");

  a_root_port: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.root_distance == '0)) |-> (out_item.root_port == '0))
    else $error("root port set while distance is zero");

endmodule

bind stp_bpdu_port_role_update_unit stp_bpdu_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
